// ----- src/assert_macros.svh -----
// Assertion macros shared by the sampler RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a condition implies a consequence on the same edge
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Check that a condition implies a consequence on the next edge
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ----- src/pecs_pkg.sv -----
// Package with constants and types of the I/O counter sampler
package pecs_pkg;
   localparam int SLOT_COUNT_DEFAULT = 64;
   localparam logic [2:0] REQ_DISK_READ  = 3'd0;
   localparam logic [2:0] REQ_DISK_WRITE = 3'd1;
   localparam logic [2:0] REQ_NET_RECV   = 3'd2;
   localparam logic [2:0] REQ_NET_SEND   = 3'd3;
   localparam logic [2:0] REQ_TICK       = 3'd4;
   localparam logic [2:0] REQ_ADD        = 3'd5;
   localparam logic [2:0] REQ_REMOVE     = 3'd6;
   localparam logic RESULT_SAMPLE = 1'b0;
   localparam logic RESULT_QUERY  = 1'b1;
   typedef logic [31:0] word_type;
endpackage

// ----- src/per_entity_io_counter_sampler_core.sv -----
// Top level of the per-entity I/O counter sampler
// The slot counters, previous values and deltas sit in one-port-read memories of SLOT_COUNT*8
// words each, with a registered read. From acceptance to the next possible acceptance, a
// transaction goes through these steps:
// - disk or net event: accept, read the byte word, write it back while reading the ops
//   word, then write the ops word back.
// - remove: accept only.
// - add: accept, then clear the 8 words of each memory one word a cycle.
// - query: accept, stream the 8 delta words through the read port, then load the result.
// - tick: accept, read one word a cycle for every slot, drain the write-back stage, then
//   load the sample (no sample is loaded on the first tick after reset).
// The result register decouples the output: a new transaction is accepted while a result
// waits, but a transaction that produces a result waits until the register frees.
`include "assert_macros.svh"
module per_entity_io_counter_sampler_core #(
   parameter int SLOT_COUNT = pecs_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [5:0]  req_slot,
   input  logic [31:0] req_entity_id,
   input  logic [31:0] req_transfer_size,
   input  logic        req_query_not_remove,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [31:0] rsp_disk_read_bytes_delta,
   output logic [31:0] rsp_disk_write_bytes_delta,
   output logic [31:0] rsp_net_recv_bytes_delta,
   output logic [31:0] rsp_net_send_bytes_delta,
   output logic [31:0] rsp_top_disk_id,
   output logic [31:0] rsp_top_net_id,
   output logic [31:0] rsp_disk_read_ops_delta,
   output logic [31:0] rsp_disk_write_ops_delta,
   output logic [31:0] rsp_net_recv_ops_delta,
   output logic [31:0] rsp_net_send_ops_delta
);
   localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int AW = SW + 3;
   localparam int DEPTH = SLOT_COUNT * 8;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EVRD  = 3'd1;
   localparam logic [2:0] ST_EVWR  = 3'd2;
   localparam logic [2:0] ST_CLEAR = 3'd3;
   localparam logic [2:0] ST_QRY   = 3'd4;
   localparam logic [2:0] ST_TICK  = 3'd5;
   localparam logic [2:0] ST_TDONE = 3'd6;
   localparam logic [2:0] ST_QDONE = 3'd7;

   // memories
   pecs_pkg::word_type cnt_mem [DEPTH];
   pecs_pkg::word_type prv_mem [DEPTH];
   pecs_pkg::word_type dlt_mem [DEPTH];
   pecs_pkg::word_type ent_mem [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] valid_ff, valid_in;

   logic [2:0] state_ff, state_in;
   logic [2:0] typ_ff, typ_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic inrng_ff, inrng_in;
   pecs_pkg::word_type size_ff, size_in, id_ff, id_in;
   logic [3:0] step_ff, step_in;   // word counter within a slot (0..8)
   logic [SW:0] sidx_ff, sidx_in;  // tick slot counter

   pecs_pkg::word_type gbytes_ff [4];
   pecs_pkg::word_type gprev_ff [4];
   pecs_pkg::word_type gdel_ff [4], gdel_in [4];
   logic seen_ff, seen_in;

   // memory ports
   logic [AW-1:0] raddr;
   logic [AW-1:0] cnt_waddr;
   logic cnt_we, pd_we;
   pecs_pkg::word_type cnt_wdata, prv_wdata, dlt_wdata;
   logic [AW-1:0] pd_waddr;
   pecs_pkg::word_type cnt_rd_ff, prv_rd_ff, dlt_rd_ff, ent_rd_ff;
   logic [SW-1:0] ent_raddr;
   logic ent_we;

   // tick scan
   pecs_pkg::word_type d0_ff, d0_in, d2_ff, d2_in;
   pecs_pkg::word_type maxd_ff, maxd_in, maxn_ff, maxn_in;
   pecs_pkg::word_type topd_ff, topd_in, topn_ff, topn_in;
   logic [3:0] wstep_ff, wstep_in;  // word index whose read data arrives now
   logic wact_ff, wact_in;
   logic [SW-1:0] wslot_ff, wslot_in;
   logic wvalid_ff, wvalid_in;

   // result register
   logic rv_ff, rv_in;
   logic rkind_ff, rkind_in;
   pecs_pkg::word_type rb_ff [4], rb_in [4], ro_ff [4], ro_in [4];
   pecs_pkg::word_type rtd_ff, rtd_in, rtn_ff, rtn_in;

   logic acc;
   logic needs_rsp;
   logic [5:0] req_slot_w;

   assign req_slot_w = req_slot;
   assign needs_rsp = (req_type == pecs_pkg::REQ_TICK) ||
                      (req_type == pecs_pkg::REQ_REMOVE && req_query_not_remove);
   assign req_ready = (state_ff == ST_IDLE) && !(needs_rsp && rv_ff);
   assign acc = req_valid && req_ready;

   pecs_pkg::word_type dnew, dsum, nsum;
   assign dnew = cnt_rd_ff - prv_rd_ff;
   assign dsum = d0_ff + dnew;
   assign nsum = d2_ff + dnew;

   always_comb begin
      state_in = state_ff;
      typ_in = typ_ff;
      slot_in = slot_ff;
      inrng_in = inrng_ff;
      size_in = size_ff;
      id_in = id_ff;
      step_in = step_ff;
      sidx_in = sidx_ff;
      valid_in = valid_ff;
      seen_in = seen_ff;
      for (int k = 0; k < 4; k++) gdel_in[k] = gdel_ff[k];
      raddr = {slot_ff, 3'd0};
      cnt_we = 1'b0;
      pd_we = 1'b0;
      cnt_waddr = {slot_ff, 3'd0};
      pd_waddr = {slot_ff, 3'd0};
      cnt_wdata = '0;
      prv_wdata = '0;
      dlt_wdata = '0;
      ent_we = 1'b0;
      ent_raddr = slot_ff;
      d0_in = d0_ff;
      d2_in = d2_ff;
      maxd_in = maxd_ff;
      maxn_in = maxn_ff;
      topd_in = topd_ff;
      topn_in = topn_ff;
      wstep_in = wstep_ff;
      wact_in = 1'b0;
      wslot_in = wslot_ff;
      wvalid_in = wvalid_ff;
      rv_in = rv_ff;
      rkind_in = rkind_ff;
      rtd_in = rtd_ff;
      rtn_in = rtn_ff;
      for (int k = 0; k < 4; k++) begin
         rb_in[k] = rb_ff[k];
         ro_in[k] = ro_ff[k];
      end
      if (rv_ff && rsp_ready) rv_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               typ_in = req_type;
               slot_in = SW'(req_slot_w);
               inrng_in = (32'(req_slot_w) < SLOT_COUNT);
               size_in = req_transfer_size;
               id_in = req_entity_id;
               step_in = '0;
               priority case (req_type)
                  pecs_pkg::REQ_DISK_READ, pecs_pkg::REQ_DISK_WRITE,
                  pecs_pkg::REQ_NET_RECV, pecs_pkg::REQ_NET_SEND: state_in = ST_EVRD;
                  pecs_pkg::REQ_TICK: begin
                     state_in = ST_TICK;
                     sidx_in = '0;
                     maxd_in = '0;
                     maxn_in = '0;
                     topd_in = '0;
                     topn_in = '0;
                  end
                  pecs_pkg::REQ_ADD: state_in = ST_CLEAR;
                  pecs_pkg::REQ_REMOVE: state_in = req_query_not_remove ? ST_QRY : ST_IDLE;
                  default: state_in = ST_IDLE;
               endcase
               if (req_type == pecs_pkg::REQ_REMOVE && !req_query_not_remove &&
                   32'(req_slot_w) < SLOT_COUNT)
                  valid_in[SW'(req_slot_w)] = 1'b0;
            end
         end
         ST_EVRD: begin
            // read byte word now, ops word next
            raddr = {slot_ff, typ_ff};
            state_in = ST_EVWR;
            step_in = 4'd0;
         end
         ST_EVWR: begin
            raddr = {slot_ff, 1'b1, typ_ff[1:0]};
            if (step_ff == 4'd0) begin
               // byte data arrives; ops read issued this cycle
               cnt_we = inrng_ff && valid_ff[slot_ff];
               cnt_waddr = {slot_ff, 1'b0, typ_ff[1:0]};
               cnt_wdata = cnt_rd_ff + size_ff;
               step_in = 4'd1;
            end else begin
               cnt_we = inrng_ff && valid_ff[slot_ff];
               cnt_waddr = {slot_ff, 1'b1, typ_ff[1:0]};
               cnt_wdata = cnt_rd_ff + 32'd1;
               state_in = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            if (inrng_ff) begin
               cnt_we = 1'b1;
               pd_we = 1'b1;
               cnt_waddr = {slot_ff, step_ff[2:0]};
               pd_waddr = {slot_ff, step_ff[2:0]};
               ent_we = (step_ff == 4'd0);
               valid_in[slot_ff] = 1'b1;
            end
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd7 || !inrng_ff) state_in = ST_IDLE;
         end
         ST_QRY: begin
            // word step-1 arrives: bytes in words 0..3, ops in words 4..7
            raddr = {slot_ff, step_ff[2:0]};
            if (step_ff != 4'd0) begin
               if (step_ff <= 4'd4)
                  rb_in[2'(step_ff - 4'd1)] = dlt_rd_ff;
               else
                  ro_in[2'(step_ff - 4'd5)] = dlt_rd_ff;
            end
            if (step_ff == 4'd8) state_in = ST_QDONE;
            step_in = step_ff + 4'd1;
         end
         ST_QDONE: begin
            if (!(inrng_ff && valid_ff[slot_ff])) begin
               for (int k = 0; k < 4; k++) begin
                  rb_in[k] = '0;
                  ro_in[k] = '0;
               end
            end
            rkind_in = pecs_pkg::RESULT_QUERY;
            rtd_in = '0;
            rtn_in = '0;
            rv_in = 1'b1;
            state_in = ST_IDLE;
         end
         ST_TICK: begin
            // issue reads of word step of slot sidx
            raddr = {sidx_ff[SW-1:0], step_ff[2:0]};
            ent_raddr = sidx_ff[SW-1:0];
            if (sidx_ff < (SW+1)'(SLOT_COUNT)) begin
               wact_in = 1'b1;
               wstep_in = step_ff;
               wslot_in = sidx_ff[SW-1:0];
               wvalid_in = valid_ff[sidx_ff[SW-1:0]];
               if (step_ff == 4'd7) begin
                  step_in = '0;
                  sidx_in = sidx_ff + (SW+1)'(1);
               end else begin
                  step_in = step_ff + 4'd1;
               end
            end else begin
               state_in = ST_TDONE;
            end
            if (sidx_ff == '0 && step_ff == '0) begin
               for (int k = 0; k < 4; k++)
                  gdel_in[k] = gbytes_ff[k] - gprev_ff[k];
            end
         end
         ST_TDONE: begin
            // the last word was already written back in the final ST_TICK state
            if (!wact_ff) begin
               if (seen_ff) begin
                  rv_in = 1'b1;
                  rkind_in = pecs_pkg::RESULT_SAMPLE;
                  for (int k = 0; k < 4; k++) begin
                     rb_in[k] = gdel_ff[k];
                     ro_in[k] = '0;
                  end
                  rtd_in = topd_ff;
                  rtn_in = topn_ff;
               end
               seen_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // tick write-back stage: data for word wstep of wslot is present
      if (wact_ff && wvalid_ff) begin
         pd_we = 1'b1;
         pd_waddr = {wslot_ff, wstep_ff[2:0]};
         prv_wdata = cnt_rd_ff;
         dlt_wdata = dnew;
         priority case (wstep_ff)
            4'd0: d0_in = dnew;
            4'd1: begin
               if (maxd_ff < dsum) begin
                  maxd_in = dsum;
                  topd_in = ent_rd_ff;
               end
            end
            4'd2: d2_in = dnew;
            4'd3: begin
               if (maxn_ff < nsum) begin
                  maxn_in = nsum;
                  topn_in = ent_rd_ff;
               end
            end
            default: ;
         endcase
      end
   end

   // global counters
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 4; k++) begin
            gbytes_ff[k] <= '0;
            gprev_ff[k] <= '0;
         end
      end else begin
         if (acc && req_type[2] == 1'b0)
            gbytes_ff[req_type[1:0]] <= gbytes_ff[req_type[1:0]] + req_transfer_size;
         if (state_ff == ST_TICK && sidx_ff == '0 && step_ff == '0)
            for (int k = 0; k < 4; k++) gprev_ff[k] <= gbytes_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      cnt_rd_ff <= cnt_mem[raddr];
      prv_rd_ff <= prv_mem[raddr];
      dlt_rd_ff <= dlt_mem[raddr];
      ent_rd_ff <= ent_mem[ent_raddr];
      if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
      if (pd_we) begin
         prv_mem[pd_waddr] <= prv_wdata;
         dlt_mem[pd_waddr] <= dlt_wdata;
      end
      if (ent_we) ent_mem[slot_ff] <= id_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         seen_ff <= 1'b0;
         rv_ff <= 1'b0;
         wact_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         seen_ff <= seen_in;
         rv_ff <= rv_in;
         wact_ff <= wact_in;
      end
      typ_ff <= typ_in;
      slot_ff <= slot_in;
      inrng_ff <= inrng_in;
      size_ff <= size_in;
      id_ff <= id_in;
      step_ff <= step_in;
      sidx_ff <= sidx_in;
      d0_ff <= d0_in;
      d2_ff <= d2_in;
      maxd_ff <= maxd_in;
      maxn_ff <= maxn_in;
      topd_ff <= topd_in;
      topn_ff <= topn_in;
      wstep_ff <= wstep_in;
      wslot_ff <= wslot_in;
      wvalid_ff <= wvalid_in;
      rkind_ff <= rkind_in;
      rtd_ff <= rtd_in;
      rtn_ff <= rtn_in;
      for (int k = 0; k < 4; k++) begin
         gdel_ff[k] <= gdel_in[k];
         rb_ff[k] <= rb_in[k];
         ro_ff[k] <= ro_in[k];
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_result_kind = rkind_ff;
   assign rsp_disk_read_bytes_delta = rb_ff[0];
   assign rsp_disk_write_bytes_delta = rb_ff[1];
   assign rsp_net_recv_bytes_delta = rb_ff[2];
   assign rsp_net_send_bytes_delta = rb_ff[3];
   assign rsp_top_disk_id = rtd_ff;
   assign rsp_top_net_id = rtn_ff;
   assign rsp_disk_read_ops_delta = ro_ff[0];
   assign rsp_disk_write_ops_delta = ro_ff[1];
   assign rsp_net_recv_ops_delta = ro_ff[2];
   assign rsp_net_send_ops_delta = ro_ff[3];

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_IMPLIES(a_busy_not_ready, clock, reset, state_ff != ST_IDLE, !req_ready)
   `ASSERT_IMPLIES(a_sample_zero_ops, clock, reset,
      rsp_valid && rsp_result_kind == pecs_pkg::RESULT_SAMPLE, rsp_disk_read_ops_delta == '0)
endmodule

// ----- tb/sv/tb.sv -----
// Testbench for the per-entity I/O counter sampler: directed and random traffic checked against a predictor
`timescale 1ns / 1ps
module tb;
   localparam int NUM_SLOTS = pecs_pkg::SLOT_COUNT_DEFAULT;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic        kind;
      logic [31:0] rd_bytes, wr_bytes, rx_bytes, tx_bytes;
      logic [31:0] top_disk, top_net;
      logic [31:0] rd_ops, wr_ops, rx_ops, tx_ops;
   } sample_type;

   class traffic_scoreboard;
      bit          live [NUM_SLOTS];
      logic [31:0] owner [NUM_SLOTS];
      logic [31:0] count [NUM_SLOTS][8];
      logic [31:0] last [NUM_SLOTS][8];
      logic [31:0] delta [NUM_SLOTS][8];
      logic [31:0] total [4];
      logic [31:0] total_last [4];
      bit          ticked;
      sample_type  pending [$];
      int          mismatches;

      function new();
         for (int s = 0; s < NUM_SLOTS; s++) begin
            live[s] = 0;
            owner[s] = 0;
            for (int k = 0; k < 8; k++) begin
               count[s][k] = 0; last[s][k] = 0; delta[s][k] = 0;
            end
         end
         for (int k = 0; k < 4; k++) begin
            total[k] = 0; total_last[k] = 0;
         end
         ticked = 0;
         mismatches = 0;
      endfunction

      function void note_request(logic [2:0] op, logic [5:0] s, logic [31:0] id,
                                 logic [31:0] size, logic qry);
         sample_type r;
         logic [31:0] best_disk, best_net, dsum, nsum;
         r = '0;
         best_disk = 0;
         best_net = 0;
         if (op <= pecs_pkg::REQ_NET_SEND) begin
            total[op[1:0]] += size;
            if (live[s]) begin
               count[s][op[1:0]] += size;
               count[s][4 + op[1:0]] += 1;
            end
         end else if (op == pecs_pkg::REQ_TICK) begin
            r.kind = pecs_pkg::RESULT_SAMPLE;
            r.rd_bytes = total[0] - total_last[0];
            r.wr_bytes = total[1] - total_last[1];
            r.rx_bytes = total[2] - total_last[2];
            r.tx_bytes = total[3] - total_last[3];
            for (int k = 0; k < 4; k++) total_last[k] = total[k];
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (!live[i]) continue;
               for (int k = 0; k < 8; k++) begin
                  delta[i][k] = count[i][k] - last[i][k];
                  last[i][k] = count[i][k];
               end
               dsum = delta[i][0] + delta[i][1];
               nsum = delta[i][2] + delta[i][3];
               if (best_disk < dsum) begin
                  best_disk = dsum; r.top_disk = owner[i];
               end
               if (best_net < nsum) begin
                  best_net = nsum; r.top_net = owner[i];
               end
            end
            if (ticked) pending.push_back(r);
            ticked = 1;
         end else if (op == pecs_pkg::REQ_ADD) begin
            live[s] = 1;
            owner[s] = id;
            for (int k = 0; k < 8; k++) begin
               count[s][k] = 0; last[s][k] = 0; delta[s][k] = 0;
            end
         end else if (op == pecs_pkg::REQ_REMOVE) begin
            if (!qry) live[s] = 0;
            else begin
               r.kind = pecs_pkg::RESULT_QUERY;
               if (live[s]) begin
                  r.rd_bytes = delta[s][0]; r.wr_bytes = delta[s][1];
                  r.rx_bytes = delta[s][2]; r.tx_bytes = delta[s][3];
                  r.rd_ops = delta[s][4]; r.wr_ops = delta[s][5];
                  r.rx_ops = delta[s][6]; r.tx_ops = delta[s][7];
               end
               pending.push_back(r);
            end
         end
      endfunction

      function void check_result(sample_type got);
         sample_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %h actual %h", want, got);
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_ready = 0, req_query_not_remove = 0;
   logic [2:0] req_type = 0;
   logic [5:0] req_slot = 0;
   logic [31:0] req_entity_id = 0, req_transfer_size = 0;
   logic req_ready, rsp_valid;
   sample_type observed;
   traffic_scoreboard board;
   int idle_cycles = 0;
   bit calm = 0;

   per_entity_io_counter_sampler_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_slot(req_slot), .req_entity_id(req_entity_id),
      .req_transfer_size(req_transfer_size), .req_query_not_remove(req_query_not_remove),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_kind(observed.kind),
      .rsp_disk_read_bytes_delta(observed.rd_bytes),
      .rsp_disk_write_bytes_delta(observed.wr_bytes),
      .rsp_net_recv_bytes_delta(observed.rx_bytes),
      .rsp_net_send_bytes_delta(observed.tx_bytes),
      .rsp_top_disk_id(observed.top_disk), .rsp_top_net_id(observed.top_net),
      .rsp_disk_read_ops_delta(observed.rd_ops),
      .rsp_disk_write_ops_delta(observed.wr_ops),
      .rsp_net_recv_ops_delta(observed.rx_ops),
      .rsp_net_send_ops_delta(observed.tx_ops)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial board = new();

   // score accepted results and watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) board.check_result(observed);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // receiver stalls about one cycle in ten, except in calm stretches
   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 10);
   end

   // called at a falling edge; returns at the falling edge after the transaction is taken
   task automatic send(logic [2:0] op, logic [5:0] s, logic [31:0] id,
                       logic [31:0] size, logic qry);
      while (!calm && $urandom_range(99) < 10) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_type <= op;
      req_slot <= s;
      req_entity_id <= id;
      req_transfer_size <= size;
      req_query_not_remove <= qry;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(op, s, id, size, qry);
      @(negedge clock);
   endtask

   // drop valid and hold off until every expected result has come
   task automatic drain();
      req_valid <= 0;
      do @(negedge clock); while (board.pending.size() != 0);
   endtask

   task automatic send_random();
      int pick;
      logic [5:0] s;
      logic [31:0] size;
      pick = $urandom_range(99);
      s = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(7));
      size = ($urandom_range(4) == 0) ? $urandom : $urandom_range(5000);
      if (pick < 55) send(3'($urandom_range(3)), s, $urandom, size, 1'($urandom));
      else if (pick < 65) send(pecs_pkg::REQ_TICK, s, $urandom, size, 1'($urandom));
      else if (pick < 73) send(pecs_pkg::REQ_ADD, s, $urandom, size, 1'($urandom));
      else if (pick < 78) send(pecs_pkg::REQ_REMOVE, s, $urandom, size, 1'b0);
      else if (pick < 98) send(pecs_pkg::REQ_REMOVE, s, $urandom, size, 1'b1);
      else send(3'd7, s, $urandom, size, 1'($urandom));
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: first tick, invalid slots, extremes, wrap, replace, remove
      send(pecs_pkg::REQ_DISK_READ, 6'd3, 32'd0, 32'd100, 1'b0);
      send(pecs_pkg::REQ_REMOVE, 6'd5, 32'd0, 32'd0, 1'b1);
      send(pecs_pkg::REQ_TICK, 6'd0, 32'd0, 32'd0, 1'b0);
      send(pecs_pkg::REQ_ADD, 6'd0, 32'hFFFFFFFF, 32'd0, 1'b0);
      send(pecs_pkg::REQ_ADD, 6'd63, 32'h00000001, 32'hFFFFFFFF, 1'b1);
      send(pecs_pkg::REQ_ADD, 6'd7, 32'hA5A5A5A5, 32'd0, 1'b0);
      send(pecs_pkg::REQ_DISK_READ, 6'd0, 32'd0, 32'hFFFFFFFF, 1'b0);
      send(pecs_pkg::REQ_DISK_WRITE, 6'd0, 32'd0, 32'd2, 1'b1);
      send(pecs_pkg::REQ_NET_RECV, 6'd63, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
      send(pecs_pkg::REQ_NET_SEND, 6'd63, 32'd0, 32'd5, 1'b1);
      send(pecs_pkg::REQ_DISK_WRITE, 6'd7, 32'd0, 32'd0, 1'b0);
      send(pecs_pkg::REQ_NET_SEND, 6'd12, 32'd0, 32'd77, 1'b0);
      send(pecs_pkg::REQ_TICK, 6'd63, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1);
      send(pecs_pkg::REQ_REMOVE, 6'd0, 32'd0, 32'd0, 1'b1);
      send(pecs_pkg::REQ_REMOVE, 6'd63, 32'd0, 32'd0, 1'b1);
      send(pecs_pkg::REQ_ADD, 6'd0, 32'h12345678, 32'd0, 1'b0);
      send(pecs_pkg::REQ_REMOVE, 6'd63, 32'd0, 32'd0, 1'b0);
      send(pecs_pkg::REQ_REMOVE, 6'd63, 32'd0, 32'd0, 1'b0);
      send(3'd7, 6'd1, 32'd0, 32'd1, 1'b1);
      send(pecs_pkg::REQ_TICK, 6'd0, 32'd0, 32'd0, 1'b0);
      send(pecs_pkg::REQ_REMOVE, 6'd63, 32'd0, 32'd0, 1'b1);
      send(pecs_pkg::REQ_REMOVE, 6'd0, 32'd0, 32'd0, 1'b1);
      for (int n = 0; n < 450; n++) begin
         calm = (n >= 150 && n < 230);
         if (n == 300) drain();
         send_random();
      end
      calm = 0;
      drain();
      repeat (600) @(posedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule

// ----- filelist.f -----
+incdir+src
src/pecs_pkg.sv
src/per_entity_io_counter_sampler_core.sv
tb/sv/tb.sv
